// File: rtl/core/matrix_multiply_dot_engine_assert.svh
// ----------------------------------------------------------------------------
// matrix multiply dot engine assertion macros
// shared property forms for the engine's concurrent checks
// ----------------------------------------------------------------------------
`ifndef MATRIX_MULTIPLY_DOT_ENGINE_ASSERT_SVH
`define MATRIX_MULTIPLY_DOT_ENGINE_ASSERT_SVH

// same-cycle implication
`define MMDE_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("mmde assertion failed");

// next-cycle implication
`define MMDE_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("mmde assertion failed");

`endif

// File: rtl/core/mmde_pkg.sv
// ----------------------------------------------------------------------------
// mmde_pkg
// shared types and codes of the matrix multiply dot engine
// ----------------------------------------------------------------------------
`default_nettype none

package mmde_pkg;

    localparam int DIM_W  = 7;
    localparam int IDX_W  = 6;
    localparam int VAL_W  = 16;
    localparam int RES_W  = 40;

    typedef logic [1:0] t_req_type;
    typedef logic [1:0] t_cmd_kind;

    localparam t_req_type REQ_WR_A = 2'd0;
    localparam t_req_type REQ_WR_B = 2'd1;
    localparam t_req_type REQ_MAC  = 2'd2;

    localparam t_cmd_kind CMD_WR_A = 2'd0;
    localparam t_cmd_kind CMD_WR_B = 2'd1;
    localparam t_cmd_kind CMD_MAC  = 2'd2;
    localparam t_cmd_kind CMD_ERR  = 2'd3;

    localparam logic [1:0] CFG_ROWS_A    = 2'd0;
    localparam logic [1:0] CFG_INNER_DIM = 2'd1;
    localparam logic [1:0] CFG_COLS_B    = 2'd2;

    localparam logic [DIM_W-1:0] DIM_RESET = 7'd64;

    typedef struct packed {
        logic signed [RES_W-1:0] dot_result;
        logic                    range_error;
    } t_result;

endpackage

`default_nettype wire

// File: rtl/core/mmde_fifo.sv
// ----------------------------------------------------------------------------
// mmde_fifo
// small register queue with first-word fall-through read
// ----------------------------------------------------------------------------
`default_nettype none

module mmde_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire logic [WIDTH-1:0] i_data,
    input  wire logic             i_pop,
    output logic [WIDTH-1:0]      o_data,
    output logic                  o_full,
    output logic                  o_empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             wr_en;
    logic             rd_en;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_data  = r_mem[r_rd_ptr];
    assign wr_en   = i_push && !o_full;
    assign rd_en   = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (wr_en) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (rd_en) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (wr_en && !rd_en) begin
                r_count <= r_count + 1'b1;
            end else if (rd_en && !wr_en) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

// File: rtl/core/mmde_front.sv
// ----------------------------------------------------------------------------
// mmde_front
// configuration registers, request intake, range check and address forming
// ----------------------------------------------------------------------------
`default_nettype none

module mmde_front #(
    parameter int MAX_DIM    = 64,
    parameter int ELEM_WIDTH = 16,
    parameter int ADDR_W     = 12
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_cfg_we,
    input  wire logic [1:0]                    i_cfg_index,
    input  wire logic [mmde_pkg::DIM_W-1:0]    i_cfg_data,
    input  wire logic                          i_push,
    input  wire logic                          i_cmd_full,
    input  wire mmde_pkg::t_req_type           i_req_type,
    input  wire logic [mmde_pkg::IDX_W-1:0]    i_row_index,
    input  wire logic [mmde_pkg::IDX_W-1:0]    i_col_index,
    input  wire logic signed [mmde_pkg::VAL_W-1:0] i_elem_value,
    output logic                               o_cmd_push,
    output mmde_pkg::t_cmd_kind                o_cmd_kind,
    output logic [ADDR_W-1:0]                  o_cmd_addr_a,
    output logic [ADDR_W-1:0]                  o_cmd_addr_b,
    output logic [ELEM_WIDTH-1:0]              o_cmd_data,
    output logic [mmde_pkg::DIM_W-1:0]         o_cmd_count
);

    import mmde_pkg::*;

    logic [DIM_W-1:0] r_rows_a;
    logic [DIM_W-1:0] r_inner_dim;
    logic [DIM_W-1:0] r_cols_b;

    logic [DIM_W-1:0] nr;
    logic [DIM_W-1:0] nk;
    logic [DIM_W-1:0] nc;
    logic [DIM_W-1:0] lim_r;
    logic [DIM_W-1:0] lim_c;
    logic [DIM_W-1:0] row_ext;
    logic [DIM_W-1:0] col_ext;
    logic             out_of_range;
    logic [ADDR_W-1:0] addr_elem;
    logic [ADDR_W-1:0] addr_row;
    logic signed [ELEM_WIDTH+VAL_W-1:0] elem_ext;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rows_a    <= DIM_RESET;
            r_inner_dim <= DIM_RESET;
            r_cols_b    <= DIM_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_ROWS_A:    r_rows_a    <= i_cfg_data;
                CFG_INNER_DIM: r_inner_dim <= i_cfg_data;
                CFG_COLS_B:    r_cols_b    <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // dimensions above the store size saturate
    assign nr = (32'(r_rows_a) > MAX_DIM) ? DIM_W'(MAX_DIM) : r_rows_a;
    assign nk = (32'(r_inner_dim) > MAX_DIM) ? DIM_W'(MAX_DIM) : r_inner_dim;
    assign nc = (32'(r_cols_b) > MAX_DIM) ? DIM_W'(MAX_DIM) : r_cols_b;

    assign row_ext = {1'b0, i_row_index};
    assign col_ext = {1'b0, i_col_index};

    always_comb begin
        case (i_req_type)
            REQ_WR_A: begin
                lim_r = nr;
                lim_c = nk;
            end
            REQ_WR_B: begin
                lim_r = nk;
                lim_c = nc;
            end
            default: begin
                lim_r = nr;
                lim_c = nc;
            end
        endcase
    end

    assign out_of_range = (row_ext >= lim_r) || (col_ext >= lim_c);
    assign addr_elem = ADDR_W'(32'(i_row_index) * MAX_DIM + 32'(i_col_index));
    assign addr_row  = ADDR_W'(32'(i_row_index) * MAX_DIM);
    assign elem_ext  = (ELEM_WIDTH + VAL_W)'(i_elem_value);

    always_comb begin
        o_cmd_push   = i_push && !i_cmd_full;
        o_cmd_kind   = CMD_ERR;
        o_cmd_addr_a = addr_elem;
        o_cmd_addr_b = addr_elem;
        o_cmd_data   = elem_ext[ELEM_WIDTH-1:0];
        o_cmd_count  = nk;
        case (i_req_type)
            REQ_WR_A: o_cmd_kind = out_of_range ? CMD_ERR : CMD_WR_A;
            REQ_WR_B: o_cmd_kind = out_of_range ? CMD_ERR : CMD_WR_B;
            REQ_MAC: begin
                o_cmd_kind   = out_of_range ? CMD_ERR : CMD_MAC;
                o_cmd_addr_a = addr_row;
                o_cmd_addr_b = ADDR_W'(i_col_index);
            end
            default: o_cmd_push = 1'b0;
        endcase
    end

endmodule

`default_nettype wire

// File: rtl/core/mmde_back.sv
// ----------------------------------------------------------------------------
// mmde_back
// element stores and the multiply-accumulate sequencer
// ----------------------------------------------------------------------------
`default_nettype none
`include "matrix_multiply_dot_engine_assert.svh"

module mmde_back #(
    parameter int MAX_DIM    = 64,
    parameter int ELEM_WIDTH = 16,
    parameter int ADDR_W     = 12
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_cq_empty,
    input  wire mmde_pkg::t_cmd_kind        i_cmd_kind,
    input  wire logic [ADDR_W-1:0]          i_cmd_addr_a,
    input  wire logic [ADDR_W-1:0]          i_cmd_addr_b,
    input  wire logic [ELEM_WIDTH-1:0]      i_cmd_data,
    input  wire logic [mmde_pkg::DIM_W-1:0] i_cmd_count,
    output logic                            o_cq_pop,
    input  wire logic                       i_rq_full,
    output logic                            o_rq_push,
    output mmde_pkg::t_result               o_rq_data
);

    import mmde_pkg::*;

    localparam int DEPTH = MAX_DIM * MAX_DIM;
    localparam int PROD_W = 2 * ELEM_WIDTH;

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_RUN   = 2'd1;
    localparam logic [1:0] S_DRAIN = 2'd2;

    logic [ELEM_WIDTH-1:0] r_mem_a [DEPTH];
    logic [ELEM_WIDTH-1:0] r_mem_b [DEPTH];

    logic [1:0]             r_state;
    logic [1:0]             n_state;
    logic [ADDR_W-1:0]      r_addr_a;
    logic [ADDR_W-1:0]      n_addr_a;
    logic [ADDR_W-1:0]      r_addr_b;
    logic [ADDR_W-1:0]      n_addr_b;
    logic [DIM_W-1:0]       r_left;
    logic [DIM_W-1:0]       n_left;
    logic                   r_rd_vld;
    logic                   r_prod_vld;
    logic signed [ELEM_WIDTH-1:0] r_rdata_a;
    logic signed [ELEM_WIDTH-1:0] r_rdata_b;
    logic signed [PROD_W-1:0]     r_prod;
    logic [RES_W-1:0]       r_acc;

    logic wr_a;
    logic wr_b;
    logic rd_en;
    logic acc_clr;

    always_comb begin
        n_state   = r_state;
        n_addr_a  = r_addr_a;
        n_addr_b  = r_addr_b;
        n_left    = r_left;
        wr_a      = 1'b0;
        wr_b      = 1'b0;
        rd_en     = 1'b0;
        acc_clr   = 1'b0;
        o_cq_pop  = 1'b0;
        o_rq_push = 1'b0;
        o_rq_data.dot_result  = '0;
        o_rq_data.range_error = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (!i_cq_empty) begin
                    case (i_cmd_kind)
                        CMD_WR_A: begin
                            wr_a     = 1'b1;
                            o_cq_pop = 1'b1;
                        end
                        CMD_WR_B: begin
                            wr_b     = 1'b1;
                            o_cq_pop = 1'b1;
                        end
                        CMD_MAC: begin
                            o_cq_pop = 1'b1;
                            acc_clr  = 1'b1;
                            n_addr_a = i_cmd_addr_a;
                            n_addr_b = i_cmd_addr_b;
                            n_left   = i_cmd_count;
                            n_state  = (i_cmd_count != '0) ? S_RUN : S_DRAIN;
                        end
                        default: begin
                            if (!i_rq_full) begin
                                o_cq_pop  = 1'b1;
                                o_rq_push = 1'b1;
                                o_rq_data.range_error = 1'b1;
                            end
                        end
                    endcase
                end
            end
            S_RUN: begin
                rd_en    = 1'b1;
                n_addr_a = r_addr_a + 1'b1;
                n_addr_b = r_addr_b + ADDR_W'(MAX_DIM);
                n_left   = r_left - 1'b1;
                if (r_left == DIM_W'(1)) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                if (!r_rd_vld && !r_prod_vld && !i_rq_full) begin
                    o_rq_push = 1'b1;
                    o_rq_data.dot_result = r_acc;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (wr_a) begin
            r_mem_a[i_cmd_addr_a] <= i_cmd_data;
        end
        if (rd_en) begin
            r_rdata_a <= r_mem_a[r_addr_a];
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_b) begin
            r_mem_b[i_cmd_addr_b] <= i_cmd_data;
        end
        if (rd_en) begin
            r_rdata_b <= r_mem_b[r_addr_b];
        end
    end

    always_ff @(posedge i_clk) begin
        r_addr_a <= n_addr_a;
        r_addr_b <= n_addr_b;
        r_left   <= n_left;
        r_prod   <= r_rdata_a * r_rdata_b;
        if (acc_clr) begin
            r_acc <= '0;
        end else if (r_prod_vld) begin
            r_acc <= r_acc + RES_W'(r_prod);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_rd_vld   <= 1'b0;
            r_prod_vld <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_rd_vld   <= rd_en;
            r_prod_vld <= r_rd_vld;
        end
    end

    `MMDE_ASSERT_SAME(a_run_count, r_state == S_RUN, r_left != '0)
    `MMDE_ASSERT_SAME(a_push_room, o_rq_push, !i_rq_full)
    `MMDE_ASSERT_SAME(a_write_idle, wr_a || wr_b, r_state == S_IDLE && !rd_en)
    `MMDE_ASSERT_NEXT(a_pipe_fill, r_state == S_RUN, r_rd_vld)
    `MMDE_ASSERT_SAME(a_push_drained, o_rq_push && r_state == S_DRAIN,
                      !r_rd_vld && !r_prod_vld)

endmodule

`default_nettype wire

// File: rtl/core/matrix_multiply_dot_engine.sv
// ----------------------------------------------------------------------------
// matrix_multiply_dot_engine
// Holds matrices A and B in two element stores and returns one element of
// C = A x B per compute request. Requests enter through a four-entry command
// queue and results leave through a two-entry result queue. A write request
// is taken by the execution unit and gives no result; a request with an
// index outside the configured dimensions gives a result with range_error
// set and a zero value once the result queue has room. For a compute
// request, one element pair per cycle is read from the two single-ported
// stores and fed through one multiplier and the 40-bit accumulator. The
// read data, the product and the sum are each registered. Dimensions above
// MAX_DIM saturate. Store entries read before being written give undefined
// values.
// ----------------------------------------------------------------------------
`default_nettype none

module matrix_multiply_dot_engine #(
    parameter int MAX_DIM    = 64,
    parameter int ELEM_WIDTH = 16
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_cfg_we,
    input  wire logic [1:0]                        i_cfg_index,
    input  wire logic [mmde_pkg::DIM_W-1:0]        i_cfg_data,
    input  wire logic                              push,
    output logic                                   full,
    input  wire logic [1:0]                        i_req_type,
    input  wire logic [mmde_pkg::IDX_W-1:0]        i_row_index,
    input  wire logic [mmde_pkg::IDX_W-1:0]        i_col_index,
    input  wire logic signed [mmde_pkg::VAL_W-1:0] i_elem_value,
    output logic                                   empty,
    input  wire logic                              pop,
    output logic signed [mmde_pkg::RES_W-1:0]      o_dot_result,
    output logic                                   o_range_error
);

    import mmde_pkg::*;

    localparam int ADDR_W   = (MAX_DIM > 1) ? $clog2(MAX_DIM * MAX_DIM) : 1;
    localparam int CMD_W    = 2 + 2 * ADDR_W + ELEM_WIDTH + DIM_W;
    localparam int CQ_DEPTH = 4;
    localparam int RQ_DEPTH = 2;

    logic                  cmd_push;
    t_cmd_kind             cmd_kind;
    logic [ADDR_W-1:0]     cmd_addr_a;
    logic [ADDR_W-1:0]     cmd_addr_b;
    logic [ELEM_WIDTH-1:0] cmd_data;
    logic [DIM_W-1:0]      cmd_count;
    logic [CMD_W-1:0]      cq_din;
    logic [CMD_W-1:0]      cq_dout;
    logic                  cq_full;
    logic                  cq_empty;
    logic                  cq_pop;

    t_cmd_kind             hd_kind;
    logic [ADDR_W-1:0]     hd_addr_a;
    logic [ADDR_W-1:0]     hd_addr_b;
    logic [ELEM_WIDTH-1:0] hd_data;
    logic [DIM_W-1:0]      hd_count;

    logic                  rq_push;
    t_result               rq_din;
    t_result               rq_dout;
    logic                  rq_full;

    assign full = cq_full;

    mmde_front #(
        .MAX_DIM    (MAX_DIM),
        .ELEM_WIDTH (ELEM_WIDTH),
        .ADDR_W     (ADDR_W)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_push       (push),
        .i_cmd_full   (cq_full),
        .i_req_type   (i_req_type),
        .i_row_index  (i_row_index),
        .i_col_index  (i_col_index),
        .i_elem_value (i_elem_value),
        .o_cmd_push   (cmd_push),
        .o_cmd_kind   (cmd_kind),
        .o_cmd_addr_a (cmd_addr_a),
        .o_cmd_addr_b (cmd_addr_b),
        .o_cmd_data   (cmd_data),
        .o_cmd_count  (cmd_count)
    );

    assign cq_din = {cmd_kind, cmd_addr_a, cmd_addr_b, cmd_data, cmd_count};

    mmde_fifo #(
        .WIDTH (CMD_W),
        .DEPTH (CQ_DEPTH)
    ) u_cmd_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (cmd_push),
        .i_data  (cq_din),
        .i_pop   (cq_pop),
        .o_data  (cq_dout),
        .o_full  (cq_full),
        .o_empty (cq_empty)
    );

    assign {hd_kind, hd_addr_a, hd_addr_b, hd_data, hd_count} = cq_dout;

    mmde_back #(
        .MAX_DIM    (MAX_DIM),
        .ELEM_WIDTH (ELEM_WIDTH),
        .ADDR_W     (ADDR_W)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cq_empty   (cq_empty),
        .i_cmd_kind   (hd_kind),
        .i_cmd_addr_a (hd_addr_a),
        .i_cmd_addr_b (hd_addr_b),
        .i_cmd_data   (hd_data),
        .i_cmd_count  (hd_count),
        .o_cq_pop     (cq_pop),
        .i_rq_full    (rq_full),
        .o_rq_push    (rq_push),
        .o_rq_data    (rq_din)
    );

    mmde_fifo #(
        .WIDTH ($bits(t_result)),
        .DEPTH (RQ_DEPTH)
    ) u_res_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (rq_push),
        .i_data  (rq_din),
        .i_pop   (pop),
        .o_data  (rq_dout),
        .o_full  (rq_full),
        .o_empty (empty)
    );

    assign o_dot_result  = rq_dout.dot_result;
    assign o_range_error = rq_dout.range_error;

endmodule

`default_nettype wire
